// File: src/ekfp_pkg.sv
package ekfp_pkg;

    localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [7:0]  KDE_ID     = 8'hDD;
    localparam logic [7:0]  OUI_B0     = 8'h00;
    localparam logic [7:0]  OUI_B1     = 8'h0F;
    localparam logic [7:0]  OUI_B2     = 8'hAC;
    localparam logic [7:0]  KDE_PMKID  = 8'h04;
    localparam logic [7:0]  TYPE_KEY   = 8'd3;
    localparam logic [7:0]  DESC_RSN   = 8'd2;
    localparam logic [7:0]  DESC_WPA   = 8'd254;
    localparam logic [16:0] MIN_LEN    = 17'd99;
    localparam logic [16:0] KD_OFFSET  = 17'd99;

    localparam logic [1:0] WALK_ON    = 2'd0;
    localparam logic [1:0] WALK_FOUND = 2'd1;
    localparam logic [1:0] WALK_END   = 2'd2;

    localparam logic [2:0] MSG_NONE = 3'd0;
    localparam logic [2:0] MSG_M1   = 3'd1;
    localparam logic [2:0] MSG_M2   = 3'd2;
    localparam logic [2:0] MSG_M3   = 3'd3;
    localparam logic [2:0] MSG_M4   = 3'd4;

    typedef struct packed {
        logic        ok;
        logic [2:0]  message;
        logic [7:0]  descriptor;
        logic [15:0] key_info;
        logic [63:0] replay_counter;
        logic [15:0] key_data_length;
        logic        nonce_zero;
        logic        mic_present;
        logic        pmkid_found;
        logic [63:0] pmkid_word;
        logic        word_index;
        logic        last;
    } result_t;

endpackage

// File: src/eapol_key_frame_parser_core.sv
// EAPOL-Key frame parser.
// Input stream s_axis_*: one payload byte per word, tlast on the final byte.
// Output stream m_axis_*: two words per frame. The first carries the frame
// summary and PMKID bytes 0..7 (tuser 0), the second PMKID bytes 8..15
// (tuser 1) with tlast set.
// Fields are captured as bytes arrive; the walk over the key data elements
// runs one byte per cycle alongside, so every byte but a frame's final one
// is taken in every cycle. The final byte is evaluated in the cycle it is
// accepted; its first result word is valid the next cycle and the second
// word follows once the receiver has taken the first.
// A final byte is held off while any word of the previous frame is still in
// the output register, so with a ready receiver a frame of three or more
// bytes never stalls the input.
// If the receiver stalls, both words stay in the output register; bytes of
// the next frame keep flowing until its final byte, which waits for the
// output register to empty.
// Reset clears all capture state, the byte counter and the output valid.
// The byte counter saturates at 131071; fields are taken only at their
// fixed offsets. After the final byte the state clears for the next frame.
module eapol_key_frame_parser_core
    import ekfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // frame_byte
    input  logic         s_axis_tlast,  // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // ok, message[3:1], descriptor[11:4], key_info[27:12], replay_counter[91:28],
    // key_data_length[107:92], nonce_zero[108], mic_present[109],
    // pmkid_found[110], pmkid_word[174:111], zero fill [175]
    output logic [175:0] m_axis_tdata,
    output logic         m_axis_tuser,  // word_index
    output logic         m_axis_tlast   // last
);

    logic [16:0] count_reg;
    logic [7:0]  type_reg, desc_reg;
    logic [15:0] info_reg, blen_reg, kdlen_reg;
    logic [63:0] replay_reg;
    logic        nz_reg;
    logic [15:0] estart_reg;
    logic [7:0]  eid_reg, elen_reg;
    logic        prefix_reg;
    logic [1:0]  walk_reg;
    logic [63:0] pm0_reg, pm1_reg;
    logic        pmnz_reg;

    // Output: shown word plus the queued second word.
    result_t     out_reg, hold_reg;
    logic        out_valid_reg, hold_valid_reg;

    logic accept;
    logic out_free;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s_axis_tlast || !out_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Walk on relative position.
    logic [16:0] d;
    logic [16:0] rel;
    logic        walk_act;
    assign d        = count_reg - KD_OFFSET;
    assign rel      = d - {1'b0, estart_reg};
    assign walk_act = (count_reg >= KD_OFFSET) && (walk_reg == WALK_ON) &&
                      (d < {1'b0, kdlen_reg}) && (d >= {1'b0, estart_reg});

    logic [17:0] st2, st2b;
    assign st2  = {2'b0, estart_reg} + 18'd2;
    assign st2b = st2 + {10'b0, s_axis_tdata};

    logic [15:0] estart_next;
    logic [7:0]  eid_next, elen_next;
    logic        prefix_next;
    logic [1:0]  walk_next;
    logic [63:0] pm0_next, pm1_next;
    logic        pmnz_next;
    logic [17:0] st2l;
    logic [4:0]  k;
    logic [7:0]  pref_b;
    logic        stop;

    assign st2l = st2 + {10'b0, elen_reg};
    assign k    = rel[4:0] - 5'd6;

    always_comb
    begin
        estart_next = estart_reg;
        eid_next    = eid_reg;
        elen_next   = elen_reg;
        prefix_next = prefix_reg;
        walk_next   = walk_reg;
        pm0_next    = pm0_reg;
        pm1_next    = pm1_reg;
        pmnz_next   = pmnz_reg;
        stop        = 1'b0;
        unique case (rel[1:0])
            2'd2:    pref_b = OUI_B0;
            2'd3:    pref_b = OUI_B1;
            2'd0:    pref_b = OUI_B2;
            default: pref_b = KDE_PMKID;
        endcase
        if (walk_act)
        begin
            if (rel == 17'd0)
            begin
                eid_next    = s_axis_tdata;
                prefix_next = 1'b0;
                if (st2 > {2'b0, kdlen_reg})
                    walk_next = WALK_END;
            end
            else if (rel == 17'd1)
            begin
                elen_next = s_axis_tdata;
                if (st2b > {2'b0, kdlen_reg})
                    walk_next = WALK_END;
                else if (s_axis_tdata == 8'd0)
                begin
                    if (eid_reg == 8'd0)
                        walk_next = WALK_END;
                    else
                        estart_next = st2[15:0];
                end
            end
            else
            begin
                if (rel <= 17'd5)
                begin
                    if (rel == 17'd2)
                        prefix_next = (eid_reg == KDE_ID) && (elen_reg >= 8'd20) &&
                                      (s_axis_tdata == pref_b);
                    else
                        prefix_next = prefix_reg && (s_axis_tdata == pref_b);
                end
                else if (prefix_reg && rel <= 17'd21)
                begin
                    if (k[3])
                        pm1_next = {pm1_reg[55:0], s_axis_tdata};
                    else
                        pm0_next = {pm0_reg[55:0], s_axis_tdata};
                    if (s_axis_tdata != 8'd0)
                        pmnz_next = 1'b1;
                    if (rel == 17'd21)
                    begin
                        walk_next = (pmnz_reg || s_axis_tdata != 8'd0) ? WALK_FOUND : WALK_END;
                        stop      = 1'b1;
                    end
                end
                if (!stop && rel == 17'd1 + {9'b0, elen_reg})
                    estart_next = st2l[15:0];
            end
        end
    end

    // Final byte evaluation, using this byte's capture.
    logic [16:0] len;
    logic [15:0] kdlen_f, info_f;
    logic [7:0]  type_f, desc_f;
    logic [15:0] blen_f;
    logic        nz_f;
    logic [63:0] replay_f;
    logic [1:0]  walk_f;
    logic [17:0] implied;
    logic        ok;
    logic [2:0]  msg;
    logic        found;
    result_t     r0, r1;

    always_comb
    begin
        type_f   = (count_reg == 17'd1) ? s_axis_tdata : type_reg;
        blen_f   = (count_reg == 17'd2 || count_reg == 17'd3) ?
                   {blen_reg[7:0], s_axis_tdata} : blen_reg;
        desc_f   = (count_reg == 17'd4) ? s_axis_tdata : desc_reg;
        info_f   = (count_reg == 17'd5 || count_reg == 17'd6) ?
                   {info_reg[7:0], s_axis_tdata} : info_reg;
        replay_f = (count_reg >= 17'd9 && count_reg <= 17'd16) ?
                   {replay_reg[55:0], s_axis_tdata} : replay_reg;
        nz_f     = nz_reg || ((count_reg >= 17'd17 && count_reg <= 17'd48) &&
                   s_axis_tdata != 8'd0);
        kdlen_f  = (count_reg == 17'd97 || count_reg == 17'd98) ?
                   {kdlen_reg[7:0], s_axis_tdata} : kdlen_reg;
        walk_f   = walk_next;
        len      = (count_reg == COUNT_MAX) ? count_reg : count_reg + 17'd1;
        implied  = {1'b0, KD_OFFSET} + {2'b0, kdlen_f};
        ok = (len >= MIN_LEN) && (type_f == TYPE_KEY) &&
             (desc_f == DESC_RSN || desc_f == DESC_WPA) && (implied <= {1'b0, len}) &&
             !(blen_f != 16'd0 && ({2'b0, blen_f} + 18'd4) != implied);
        msg = MSG_NONE;
        if (ok && info_f[3] && !info_f[11])
        begin
            if (info_f[7] && !info_f[8])
                msg = MSG_M1;
            else if (info_f[7] && info_f[8])
                msg = MSG_M3;
            else if (info_f[8])
                msg = (!info_f[9] && kdlen_f != 16'd0) ? MSG_M2 : MSG_M4;
        end
        found = ok && msg == MSG_M1 && !info_f[12] && kdlen_f != 16'd0 &&
                walk_f == WALK_FOUND;
        r0 = '0;
        r1 = '0;
        if (ok)
        begin
            r0.ok              = 1'b1;
            r0.message         = msg;
            r0.descriptor      = desc_f;
            r0.key_info        = info_f;
            r0.replay_counter  = replay_f;
            r0.key_data_length = kdlen_f;
            r0.nonce_zero      = !nz_f;
            r0.mic_present     = info_f[8];
        end
        if (found)
        begin
            r0.pmkid_found = 1'b1;
            r0.pmkid_word  = pm0_next;
            r1.pmkid_found = 1'b1;
            r1.pmkid_word  = pm1_next;
        end
        r1.word_index = 1'b1;
        r1.last       = 1'b1;
    end

    // A final byte is only accepted while the output register is empty.
    logic take;
    assign take = accept && s_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            type_reg   <= '0;
            desc_reg   <= '0;
            info_reg   <= '0;
            blen_reg   <= '0;
            replay_reg <= '0;
            kdlen_reg  <= '0;
            nz_reg     <= 1'b0;
            estart_reg <= '0;
            eid_reg    <= '0;
            elen_reg   <= '0;
            prefix_reg <= 1'b0;
            walk_reg   <= WALK_ON;
            pm0_reg    <= '0;
            pm1_reg    <= '0;
            pmnz_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_axis_tlast)
            begin
                count_reg  <= '0;
                type_reg   <= '0;
                desc_reg   <= '0;
                info_reg   <= '0;
                blen_reg   <= '0;
                replay_reg <= '0;
                kdlen_reg  <= '0;
                nz_reg     <= 1'b0;
                estart_reg <= '0;
                eid_reg    <= '0;
                elen_reg   <= '0;
                prefix_reg <= 1'b0;
                walk_reg   <= WALK_ON;
                pm0_reg    <= '0;
                pm1_reg    <= '0;
                pmnz_reg   <= 1'b0;
            end
            else
            begin
                if (count_reg != COUNT_MAX)
                    count_reg <= count_reg + 17'd1;
                type_reg   <= type_f;
                desc_reg   <= desc_f;
                info_reg   <= info_f;
                blen_reg   <= blen_f;
                replay_reg <= replay_f;
                kdlen_reg  <= kdlen_f;
                nz_reg     <= nz_f;
                estart_reg <= estart_next;
                eid_reg    <= eid_next;
                elen_reg   <= elen_next;
                prefix_reg <= prefix_next;
                walk_reg   <= walk_next;
                pm0_reg    <= pm0_next;
                pm1_reg    <= pm1_next;
                pmnz_reg   <= pmnz_next;
            end
        end
    end

    // Output queue: out_reg shown, hold_reg behind it (at most two words).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg  <= 1'b1;
            hold_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg  <= hold_valid_reg;
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg  <= r0;
            hold_reg <= r1;
        end
        else if (out_free)
        begin
            out_reg <= hold_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tuser  = out_reg.word_index;
    assign m_axis_tdata  = {1'b0, out_reg.pmkid_word,
                            out_reg.pmkid_found, out_reg.mic_present,
                            out_reg.nonce_zero, out_reg.key_data_length,
                            out_reg.replay_counter, out_reg.key_info,
                            out_reg.descriptor, out_reg.message, out_reg.ok};

    a_hold_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("second word queued without a shown word");
    a_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tlast && out_valid_reg) |-> !s_axis_tready)
        else $error("final byte accepted while output busy");
    a_first_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (m_axis_tvalid && !m_axis_tlast && !m_axis_tuser))
        else $error("first word of frame not shown");
    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("second word without last mark");
    a_walk_code: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_reg == WALK_ON || walk_reg == WALK_FOUND || walk_reg == WALK_END))
        else $error("bad walk status");

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench
    import ekfp_pkg::*;
();

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'd0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    typedef struct {
        logic        ok;
        logic [2:0]  message;
        logic [7:0]  descriptor;
        logic [15:0] key_info;
        logic [63:0] replay_counter;
        logic [15:0] key_data_length;
        logic        nonce_zero;
        logic        mic_present;
        logic        pmkid_found;
        logic [63:0] pmkid_word;
        logic        word_index;
        logic        last;
    } summary_t;

    summary_t pending_words[$];
    int errors = 0;
    int frames_sent = 0;
    int bytes_sent = 0;
    int words_checked = 0;
    int send_idle_pct = 6;
    int recv_idle_pct = 54;

    // Parser state mirror.
    logic [16:0] cnt;
    logic [7:0]  ftype, desc;
    logic [15:0] kinfo, blen, kdlen, el_start;
    logic [63:0] replay;
    logic        nonce_nz, prefix_ok, pm_nz;
    logic [7:0]  el_id, el_len;
    logic [1:0]  walk;
    logic [63:0] pm [2];

    eapol_key_frame_parser_core uut (.*);

    always #6 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic clear_parser();
        cnt = '0; ftype = '0; desc = '0; kinfo = '0; blen = '0; kdlen = '0; el_start = '0;
        replay = '0; nonce_nz = 1'b0; prefix_ok = 1'b0; pm_nz = 1'b0; el_id = '0;
        el_len = '0; walk = WALK_ON; pm[0] = '0; pm[1] = '0;
    endtask

    task automatic walk_key_data(input int d, input logic [7:0] b);
        int rel;
        int k;
        logic [7:0] want;
        if (walk != WALK_ON || d >= kdlen || d < el_start)
            return;
        rel = d - el_start;
        if (rel == 0)
        begin
            el_id = b;
            prefix_ok = 1'b0;
            if (el_start + 2 > kdlen)
                walk = WALK_END;
            return;
        end
        if (rel == 1)
        begin
            el_len = b;
            if (el_start + 2 + b > kdlen)
                walk = WALK_END;
            else if (b == 0)
            begin
                if (el_id == 0)
                    walk = WALK_END;
                else
                    el_start = 16'(el_start + 2);
            end
            return;
        end
        if (rel <= 5)
        begin
            case (rel)
                2: want = OUI_B0;
                3: want = OUI_B1;
                4: want = OUI_B2;
                default: want = KDE_PMKID;
            endcase
            if (rel == 2)
                prefix_ok = (el_id == KDE_ID) && (el_len >= 20) && (b == want);
            else
                prefix_ok = prefix_ok && (b == want);
        end
        else if (prefix_ok && rel <= 21)
        begin
            k = rel - 6;
            pm[k / 8] = {pm[k / 8][55:0], b};
            if (b != 0)
                pm_nz = 1'b1;
            if (rel == 21)
            begin
                walk = pm_nz ? WALK_FOUND : WALK_END;
                return;
            end
        end
        if (rel == 1 + el_len)
            el_start = 16'(el_start + 2 + el_len);
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        int p;
        int implied;
        logic ok, found, ack, mic, sec;
        logic [2:0] msg;
        summary_t w0, w1;
        p = int'(cnt);
        if (p == 1)
            ftype = b;
        else if (p == 2 || p == 3)
            blen = {blen[7:0], b};
        else if (p == 4)
            desc = b;
        else if (p == 5 || p == 6)
            kinfo = {kinfo[7:0], b};
        else if (p >= 9 && p <= 16)
            replay = {replay[55:0], b};
        else if (p >= 17 && p <= 48)
        begin
            if (b != 0)
                nonce_nz = 1'b1;
        end
        else if (p == 97 || p == 98)
            kdlen = {kdlen[7:0], b};
        else if (p >= 99)
            walk_key_data(p - 99, b);
        if (cnt < COUNT_MAX)
            cnt = cnt + 17'd1;
        if (!fin)
            return;
        implied = 99 + kdlen;
        ok = cnt >= MIN_LEN && ftype == TYPE_KEY && (desc == DESC_RSN || desc == DESC_WPA)
             && implied <= cnt && !(blen != 0 && blen + 4 != implied);
        msg = MSG_NONE;
        ack = kinfo[7];
        mic = kinfo[8];
        sec = kinfo[9];
        if (ok && kinfo[3] && !kinfo[11])
        begin
            if (ack && !mic)
                msg = MSG_M1;
            else if (ack && mic)
                msg = MSG_M3;
            else if (mic)
                msg = (!sec && kdlen > 0) ? MSG_M2 : MSG_M4;
        end
        found = ok && msg == MSG_M1 && !kinfo[12] && kdlen > 0 && walk == WALK_FOUND;
        w0 = '{default: 0};
        w1 = '{default: 0};
        if (ok)
        begin
            w0.ok = 1'b1; w0.message = msg; w0.descriptor = desc; w0.key_info = kinfo;
            w0.replay_counter = replay; w0.key_data_length = kdlen;
            w0.nonce_zero = !nonce_nz; w0.mic_present = kinfo[8];
        end
        if (found)
        begin
            w0.pmkid_found = 1'b1; w0.pmkid_word = pm[0];
            w1.pmkid_found = 1'b1; w1.pmkid_word = pm[1];
        end
        w1.word_index = 1'b1;
        w1.last = 1'b1;
        pending_words.push_back(w0);
        pending_words.push_back(w1);
        clear_parser();
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_byte(b, fin);
        bytes_sent++;
        if (fin)
            frames_sent++;
    endtask

    task automatic send_frame(input logic [7:0] fr[$]);
        foreach (fr[i])
            send_byte(fr[i], i == fr.size() - 1);
    endtask

    // Builds a well-formed EAPOL-Key frame with the given key info and key data.
    task automatic build_frame(output logic [7:0] fr[$], input logic [15:0] ki,
                               input logic [7:0] kd[$], input logic [7:0] dsc,
                               input logic zero_nonce);
        int n;
        n = 95 + kd.size();
        fr = {};
        for (int i = 0; i < 99; i++)
            fr.push_back(8'($urandom_range(255, 0)));
        fr[0] = 8'($urandom_range(3, 1));
        fr[1] = TYPE_KEY;
        fr[2] = n[15:8];
        fr[3] = n[7:0];
        fr[4] = dsc;
        fr[5] = ki[15:8];
        fr[6] = ki[7:0];
        if (zero_nonce)
            for (int i = 17; i <= 48; i++)
                fr[i] = 8'd0;
        fr[97] = 8'(kd.size() / 256);
        fr[98] = 8'(kd.size() % 256);
        foreach (kd[i])
            fr.push_back(kd[i]);
    endtask

    function automatic void add_pmkid(ref logic [7:0] kd[$], input logic zero_id);
        kd.push_back(KDE_ID);
        kd.push_back(8'd20);
        kd.push_back(OUI_B0);
        kd.push_back(OUI_B1);
        kd.push_back(OUI_B2);
        kd.push_back(KDE_PMKID);
        for (int i = 0; i < 16; i++)
            kd.push_back(zero_id ? 8'd0 : 8'($urandom_range(255, 0)));
    endfunction

    function automatic void add_element(ref logic [7:0] kd[$]);
        int l;
        l = $urandom_range(2) == 0 ? 0 : $urandom_range(24, 1);
        kd.push_back(8'($urandom_range(255, 0)));
        kd.push_back(8'(l));
        for (int i = 0; i < l; i++)
            kd.push_back(8'($urandom_range(255, 0)));
    endfunction

    // Pick the key info of one of the four handshake messages or a random one.
    function automatic logic [15:0] pick_key_info();
        logic [15:0] ki;
        ki = 16'($urandom_range(16'hFFFF, 0));
        case ($urandom_range(5, 0))
            0, 1: ki = 16'h008A;
            2: ki = 16'h010A;
            3: ki = 16'h13CA;
            4: ki = 16'h030A;
            default: ;
        endcase
        if ($urandom_range(3, 0) == 0)
            ki[2:0] = 3'($urandom_range(7, 0));
        return ki;
    endfunction

    function automatic int check_field(string nm, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch %s expected %h actual %h", $time, nm, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            summary_t w;
            int bad;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                w = pending_words.pop_front();
                bad = 0;
                bad += check_field("ok", 64'(w.ok), 64'(m_axis_tdata[0]));
                bad += check_field("message", 64'(w.message), 64'(m_axis_tdata[3:1]));
                bad += check_field("descriptor", 64'(w.descriptor),
                                   64'(m_axis_tdata[11:4]));
                bad += check_field("key_info", 64'(w.key_info), 64'(m_axis_tdata[27:12]));
                bad += check_field("replay_counter", w.replay_counter, m_axis_tdata[91:28]);
                bad += check_field("key_data_length", 64'(w.key_data_length),
                                   64'(m_axis_tdata[107:92]));
                bad += check_field("nonce_zero", 64'(w.nonce_zero), 64'(m_axis_tdata[108]));
                bad += check_field("mic_present", 64'(w.mic_present),
                                   64'(m_axis_tdata[109]));
                bad += check_field("pmkid_found", 64'(w.pmkid_found),
                                   64'(m_axis_tdata[110]));
                bad += check_field("pmkid_word", w.pmkid_word, m_axis_tdata[174:111]);
                bad += check_field("zero fill", 64'd0, 64'(m_axis_tdata[175]));
                bad += check_field("word_index", 64'(w.word_index), 64'(m_axis_tuser));
                bad += check_field("last", 64'(w.last), 64'(m_axis_tlast));
                if (bad != 0)
                    errors++;
                words_checked++;
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] fr[$];
        logic [7:0] kd[$];
        // Unencrypted M1 carrying a PMKID, RSN and WPA descriptors.
        kd = {}; add_pmkid(kd, 1'b0);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b1); send_frame(fr);
        kd = {}; add_element(kd); add_pmkid(kd, 1'b0);
        build_frame(fr, 16'h008A, kd, DESC_WPA, 1'b0); send_frame(fr);
        // All-zero PMKID.
        kd = {}; add_pmkid(kd, 1'b1);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b1); send_frame(fr);
        // Zero padding element ends the walk.
        kd = {8'd0, 8'd0}; add_pmkid(kd, 1'b0);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); send_frame(fr);
        // Truncated element.
        kd = {8'hDD, 8'd40}; add_pmkid(kd, 1'b0);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); send_frame(fr);
        // Encrypted key data flag on M1.
        kd = {}; add_pmkid(kd, 1'b0);
        build_frame(fr, 16'h108A, kd, DESC_RSN, 1'b0); send_frame(fr);
        // M2, M3, M4, M2 flags without key data, request.
        kd = {}; add_element(kd);
        build_frame(fr, 16'h010A, kd, DESC_RSN, 1'b0); send_frame(fr);
        build_frame(fr, 16'h13CA, kd, DESC_RSN, 1'b0); send_frame(fr);
        kd = {};
        build_frame(fr, 16'h030A, kd, DESC_RSN, 1'b1); send_frame(fr);
        build_frame(fr, 16'h010A, kd, DESC_RSN, 1'b1); send_frame(fr);
        build_frame(fr, 16'h088A, kd, DESC_RSN, 1'b0); send_frame(fr);
    endtask

    task automatic test_rejects();
        logic [7:0] fr[$];
        logic [7:0] kd[$];
        kd = {};
        // Bad type, bad descriptor, short frame, single byte, bad body length.
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); fr[1] = 8'd0; send_frame(fr);
        build_frame(fr, 16'h008A, kd, 8'd1, 1'b0); send_frame(fr);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); fr.pop_back(); send_frame(fr);
        fr = {8'hFF}; send_frame(fr);
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); fr[3] = 8'hFF; send_frame(fr);
        // Key data length claims more than received.
        build_frame(fr, 16'h008A, kd, DESC_RSN, 1'b0); fr[97] = 8'hFF; fr[98] = 8'hFF;
        fr[2] = 8'd0; fr[3] = 8'd0; send_frame(fr);
    endtask

    task automatic test_random(input int budget);
        logic [7:0] fr[$];
        logic [7:0] kd[$];
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            kd = {};
            if ($urandom_range(9, 0) < 8)
            begin
                repeat ($urandom_range(2, 0)) add_element(kd);
                if ($urandom_range(3, 0) != 0)
                    add_pmkid(kd, $urandom_range(15, 0) == 0);
                if ($urandom_range(3, 0) == 0)
                    add_element(kd);
                build_frame(fr, pick_key_info(), kd,
                            $urandom_range(1, 0) ? DESC_RSN : DESC_WPA,
                            1'($urandom_range(1, 0)));
                case ($urandom_range(9, 0))
                    0: fr[$urandom_range(fr.size() - 1, 0)] = 8'($urandom_range(255, 0));
                    1: if (kd.size() > 0) fr.pop_back();
                    2: fr.push_back(8'($urandom_range(255, 0)));
                    3:
                    begin
                        fr[2] = 8'd0;
                        fr[3] = 8'd0;
                    end
                    default: ;
                endcase
            end
            else
            begin
                fr = {};
                repeat ($urandom_range(130, 1)) fr.push_back(8'($urandom_range(255, 0)));
            end
            send_frame(fr);
        end
    endtask

    initial
    begin
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        // Hold the sender until every word has drained.
        wait_drained();
        send_idle_pct = 54;
        recv_idle_pct = 6;
        test_rejects();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(100);
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d frames (%0d bytes), checked %0d result words,", frames_sent,
                 bytes_sent, words_checked);
        $display("including all message kinds, PMKID cases and rejected frames.");
        if (errors == 0 && pending_words.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
